// ===== design/cptr_pkg.sv =====
`default_nettype none

package cptr_pkg;

  localparam int WordW  = 32;
  localparam int IndexW = 15;
  localparam int CountW = 15;
  localparam int PairW  = 11;
  localparam int PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_HEADER = 3'd0;
  localparam logic [PhaseW-1:0] PH_SEQ    = 3'd1;
  localparam logic [PhaseW-1:0] PH_PAIR1  = 3'd2;
  localparam logic [PhaseW-1:0] PH_PAIR2  = 3'd3;
  localparam logic [PhaseW-1:0] PH_SKIP   = 3'd4;

  localparam logic [1:0] PKT_SEQ    = 2'd0;
  localparam logic [1:0] PKT_PAIR   = 2'd1;
  localparam logic [1:0] PKT_FILLER = 2'd2;
  localparam logic [1:0] PKT_SKIP   = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [IndexW-1:0] reg_index;
    logic [WordW-1:0]  reg_value;
  } out_t;

  typedef struct packed {
    logic [PhaseW-1:0] parse_phase;
    logic [CountW-1:0] words_left;
    logic [IndexW-1:0] current_register;
    logic              hold_register;
    logic [PairW-1:0]  second_pair_register;
  } track_state_t;

  localparam track_state_t STATE_RESET = '{
    parse_phase:          PH_HEADER,
    words_left:           '0,
    current_register:     '0,
    hold_register:        1'b0,
    second_pair_register: '0
  };

endpackage

`default_nettype wire

// ===== design/cptr_decode.sv =====
`default_nettype none

module cptr_decode
  import cptr_pkg::*;
(
  input  track_state_t cur,
  input  in_t          req,
  output track_state_t nxt,
  output logic         emit,
  output out_t         res
);

  logic [1:0]        pkt_type;
  logic [CountW-1:0] count_plus1;
  logic [CountW-1:0] left_dec;

  assign pkt_type    = req.word[31:30];
  assign count_plus1 = {1'b0, req.word[29:16]} + CountW'(1);
  assign left_dec    = cur.words_left - CountW'(1);

  always_comb begin
    nxt           = cur;
    emit          = 1'b0;
    res.reg_index = '0;
    res.reg_value = '0;
    case (cur.parse_phase)
      PH_SEQ: begin
        emit          = 1'b1;
        res.reg_index = cur.current_register;
        res.reg_value = req.word;
        if (!cur.hold_register) begin
          nxt.current_register = cur.current_register + IndexW'(1);
        end
        nxt.words_left = left_dec;
        if (left_dec == '0) begin
          nxt.parse_phase = PH_HEADER;
        end
      end
      PH_PAIR1: begin
        emit            = 1'b1;
        res.reg_index   = cur.current_register;
        res.reg_value   = req.word;
        nxt.parse_phase = PH_PAIR2;
      end
      PH_PAIR2: begin
        emit            = 1'b1;
        res.reg_index   = IndexW'(cur.second_pair_register);
        res.reg_value   = req.word;
        nxt.parse_phase = PH_HEADER;
        nxt.words_left  = '0;
      end
      PH_SKIP: begin
        nxt.words_left = left_dec;
        if (left_dec == '0) begin
          nxt.parse_phase = PH_HEADER;
        end
      end
      default: begin
        case (pkt_type)
          PKT_SEQ: begin
            nxt.current_register = IndexW'(req.word[12:0]);
            nxt.hold_register    = req.word[15];
            nxt.words_left       = count_plus1;
            nxt.parse_phase      = PH_SEQ;
          end
          PKT_PAIR: begin
            nxt.current_register     = IndexW'(req.word[10:0]);
            nxt.second_pair_register = req.word[21:11];
            nxt.parse_phase          = PH_PAIR1;
          end
          PKT_FILLER: begin
            nxt.parse_phase = PH_HEADER;
            nxt.words_left  = '0;
          end
          default: begin
            nxt.words_left  = count_plus1;
            nxt.parse_phase = PH_SKIP;
          end
        endcase
      end
    endcase
    if (req.end_of_buffer) begin
      nxt.parse_phase = PH_HEADER;
      nxt.words_left  = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/command_packet_register_tracker_core.sv =====
`default_nettype none

// Command stream register-write tracker. One 32-bit stream word is taken per
// request on the in_ channel, one per clock cycle while the consumer keeps
// up; each word that carries a register value yields one register write on
// the out_ channel in the cycle after it is accepted, and headers, filler and
// skipped words yield nothing. The parser state updates in the accepting
// cycle and the write lands in a single result register, so the input stalls
// only while that register holds a write the consumer has not taken. Setting
// end_of_buffer on a word processes it normally, then drops any open packet
// and expects a header next.
module command_packet_register_tracker_core
  import cptr_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_ready,
  output out_t out_data
);

  track_state_t state_r;
  track_state_t state_nxt;
  logic         emit;
  out_t         res;
  logic         in_fire;
  logic         out_valid_r;
  out_t         out_data_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cptr_decode u_decode (
    .cur  (state_r),
    .req  (in_data),
    .nxt  (state_nxt),
    .emit (emit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/cptr_checker.sv =====
`default_nettype none

module cptr_checker
  import cptr_pkg::*;
(
  input wire  clk,
  input wire  rst_n,
  input wire  in_valid,
  input wire  in_ready,
  input wire  out_valid,
  input wire  out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while result register is blocked");

  a_no_result_without_request: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) && !(out_valid && !out_ready) |=> !out_valid)
    else $error("result appeared without a request");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind command_packet_register_tracker_core cptr_checker u_cptr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
